// ----- hw/rtl/firconv_pkg.sv -----
// Shared constants, codes and types of the full-convolution FIR filter.
package firconv_pkg;

   // Filter size and field widths.
   localparam int MAX_TAPS    = 16;
   localparam int SAMPLE_W    = 16;
   localparam int COEF_W      = 16;
   localparam int INDEX_W     = 4;
   localparam int TAP_W       = 5;
   localparam int PROD_W      = SAMPLE_W + COEF_W;
   localparam int RESULT_W    = 36;
   localparam int EFF_W       = $clog2(MAX_TAPS + 1);
   localparam int CNT_W       = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int TREE_LEVELS = $clog2(MAX_TAPS);

   // Action codes of an input item.
   localparam logic ACT_COEFF  = 1'b0;
   localparam logic ACT_SAMPLE = 1'b1;

   // Tap count after reset.
   localparam logic [TAP_W-1:0] TAP_RESET = TAP_W'(16);

   // One input item.
   typedef struct packed {
      logic                       action;
      logic signed [SAMPLE_W-1:0] sample;
      logic [INDEX_W-1:0]         coeff_index;
      logic signed [COEF_W-1:0]   coeff_value;
      logic                       last;
   } req_item_type;

   // Coefficient write toward the cell row.
   typedef struct packed {
      logic                     en;
      logic [INDEX_W-1:0]       index;
      logic signed [COEF_W-1:0] value;
   } coef_wr_type;

   // One step of the sample chain: a real sample or a zero of the tail.
   typedef struct packed {
      logic                       go;
      logic                       seq_end;
      logic signed [SAMPLE_W-1:0] data;
   } step_type;

   // Sideband that travels with a sum through the adder tree.
   typedef struct packed {
      logic valid;
      logic last;
   } side_type;

endpackage

// ----- hw/rtl/firconv_if.sv -----
// Channel interfaces of the FIR filter: input items, results and tap count writes.
interface firconv_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   action;
   logic signed [firconv_pkg::SAMPLE_W-1:0] sample;
   logic [firconv_pkg::INDEX_W-1:0]        coeff_index;
   logic signed [firconv_pkg::COEF_W-1:0]  coeff_value;
   logic                                   last;

   modport source (output valid, action, sample, coeff_index, coeff_value, last,
                   input ready);
   modport sink (input valid, action, sample, coeff_index, coeff_value, last,
                 output ready);
endinterface

interface firconv_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [firconv_pkg::RESULT_W-1:0] result;
   logic                                   last_out;

   modport source (output valid, result, last_out, input ready);
   modport sink (input valid, result, last_out, output ready);
endinterface

interface firconv_csr_if;
   logic                             valid;
   logic                             ready;
   logic [firconv_pkg::TAP_W-1:0]    tap_count;

   modport source (output valid, tap_count, input ready);
   modport sink (input valid, tap_count, output ready);
endinterface

// ----- hw/rtl/fir_full_convolution_unit.sv -----
// Top level of the full-convolution FIR filter: tap cell row, adder tree, sequencer.
// Pipeline: a result is valid once its sample has passed the product register and a
// four-level registered adder tree; the tap chain takes one step a cycle unless stalled.
// Throughput: one item per cycle while the output is not stalled; a sample marked last
// holds off the input while zeros, one per tap in use beyond the first, fill the tail.
// Reset clears all coefficients and the history, sets the tap count to 16 and empties the
// pipeline. Output stalls freeze the whole pipeline and the input.
module fir_full_convolution_unit (
   input  logic          clock,
   input  logic          reset,
   firconv_req_if.sink   req_chan,
   firconv_rsp_if.source rsp_chan,
   firconv_csr_if.sink   csr_chan
);
   import firconv_pkg::*;

   logic                       advance;
   req_item_type               req_item;
   coef_wr_type                coef_wr;
   step_type                   step;
   logic [EFF_W-1:0]           m_eff;
   side_type                   side_in;
   side_type                   side_out;
   logic signed [SAMPLE_W-1:0] chain [0:MAX_TAPS];
   logic signed [PROD_W-1:0]   prod [MAX_TAPS];
   logic signed [RESULT_W-1:0] result;

   // The pipeline moves whenever the output register is free or being emptied.
   assign advance = !side_out.valid || rsp_chan.ready;

   // Gather the input payload.
   assign req_item.action      = req_chan.action;
   assign req_item.sample      = req_chan.sample;
   assign req_item.coeff_index = req_chan.coeff_index;
   assign req_item.coeff_value = req_chan.coeff_value;
   assign req_item.last        = req_chan.last;

   firconv_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .req_valid     (req_chan.valid),
      .req_item      (req_item),
      .req_ready     (req_chan.ready),
      .csr_valid     (csr_chan.valid),
      .csr_tap_count (csr_chan.tap_count),
      .csr_ready     (csr_chan.ready),
      .coef_wr       (coef_wr),
      .step          (step),
      .m_eff         (m_eff)
   );

   // Row of tap cells; the newest sample enters cell zero.
   assign chain[0] = step.data;
   for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
      firconv_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .step_go    (step.go),
         .step_clear (step.seq_end),
         .tap_en     (EFF_W'(k) < m_eff),
         .coef_we    (coef_wr.en && (int'(coef_wr.index) == k)),
         .coef_value (coef_wr.value),
         .data_in    (chain[k]),
         .data_out   (chain[k+1]),
         .prod_out   (prod[k])
      );
   end

   // Sum the products; valid and last follow the sum.
   assign side_in.valid = step.go;
   assign side_in.last  = step.seq_end;

   firconv_sum_tree u_sum_tree (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .side_in  (side_in),
      .prod     (prod),
      .side_out (side_out),
      .result   (result)
   );

   // The tree root is the output register.
   assign rsp_chan.valid    = side_out.valid;
   assign rsp_chan.last_out = side_out.last;
   assign rsp_chan.result   = result;

endmodule

// ----- hw/rtl/firconv_cell.sv -----
// One tap cell: holds a coefficient and a history sample, forms its product.
module firconv_cell (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    advance,
   input  logic                                    step_go,
   input  logic                                    step_clear,
   input  logic                                    tap_en,
   input  logic                                    coef_we,
   input  logic signed [firconv_pkg::COEF_W-1:0]   coef_value,
   input  logic signed [firconv_pkg::SAMPLE_W-1:0] data_in,
   output logic signed [firconv_pkg::SAMPLE_W-1:0] data_out,
   output logic signed [firconv_pkg::PROD_W-1:0]   prod_out
);
   import firconv_pkg::*;

   logic signed [COEF_W-1:0]   coef_ff;
   logic signed [SAMPLE_W-1:0] hold_ff;
   logic signed [SAMPLE_W-1:0] hold_in;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [PROD_W-1:0]   prod_in;

   // The product of the sample arriving at this tap; unused taps give zero.
   always_comb begin
      if (tap_en) begin
         prod_in = coef_ff * data_in;
      end else begin
         prod_in = '0;
      end
   end

   // On a step the sample moves on to the next cell; the last step of a sequence
   // empties the history.
   always_comb begin
      hold_in = step_clear ? '0 : data_in;
   end

   // Coefficient and history registers, both cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
         hold_ff <= '0;
      end else begin
         if (coef_we) begin
            coef_ff <= coef_value;
         end
         if (step_go) begin
            hold_ff <= hold_in;
         end
      end
   end

   // Product register, first stage of the summing pipeline.
   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
      end
   end

   assign data_out = hold_ff;
   assign prod_out = prod_ff;

endmodule

// ----- hw/rtl/firconv_sum_tree.sv -----
// Registered binary adder tree that sums the tap products, with sideband.
module firconv_sum_tree (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           advance,
   input  firconv_pkg::side_type                          side_in,
   input  logic signed [firconv_pkg::PROD_W-1:0]          prod [firconv_pkg::MAX_TAPS],
   output firconv_pkg::side_type                          side_out,
   output logic signed [firconv_pkg::RESULT_W-1:0]        result
);
   import firconv_pkg::*;

   // Heap layout: node 1 is the root, leaves sit at MAX_TAPS and above.
   logic signed [RESULT_W-1:0] node_w  [1:2*MAX_TAPS-1];
   logic signed [RESULT_W-1:0] node_ff [1:MAX_TAPS-1];
   side_type                   side_ff [0:TREE_LEVELS];

   // Leaves are the sign-extended products.
   for (genvar k = 0; k < MAX_TAPS; k++) begin : g_leaf
      assign node_w[MAX_TAPS + k] = {{(RESULT_W - PROD_W){prod[k][PROD_W-1]}}, prod[k]};
   end

   // Every inner node adds its two children and registers the sum.
   for (genvar i = 1; i < MAX_TAPS; i++) begin : g_node
      assign node_w[i] = node_ff[i];
      always_ff @(posedge clock) begin
         if (advance) begin
            node_ff[i] <= node_w[2*i] + node_w[2*i + 1];
         end
      end
   end

   // Valid and last bits ride along with the product stage and each tree level.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= TREE_LEVELS; j++) begin
            side_ff[j] <= '0;
         end
      end else if (advance) begin
         side_ff[0] <= side_in;
         for (int j = 1; j <= TREE_LEVELS; j++) begin
            side_ff[j] <= side_ff[j-1];
         end
      end
   end

   assign side_out = side_ff[TREE_LEVELS];
   assign result   = node_ff[1];

endmodule

// ----- hw/rtl/firconv_ctrl.sv -----
// Sequencer: input handshake, tap count register and the zero-filled tail flush.
module firconv_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic                               req_valid,
   input  firconv_pkg::req_item_type          req_item,
   output logic                               req_ready,
   input  logic                               csr_valid,
   input  logic [firconv_pkg::TAP_W-1:0]      csr_tap_count,
   output logic                               csr_ready,
   output firconv_pkg::coef_wr_type           coef_wr,
   output firconv_pkg::step_type              step,
   output logic [firconv_pkg::EFF_W-1:0]      m_eff
);
   import firconv_pkg::*;

   logic [TAP_W-1:0] tap_count_ff;
   logic [CNT_W-1:0] flush_cnt_ff;
   logic [CNT_W-1:0] flush_cnt_in;
   logic             flushing;
   logic             accept;
   logic             take_sample;

   // Tap count register; writes are for the user to make only while the block is idle, the block does not enforce it.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= TAP_RESET;
      end else if (csr_valid) begin
         tap_count_ff <= csr_tap_count;
      end
   end

   // Effective tap count: zero acts as one, large values saturate.
   always_comb begin
      if (tap_count_ff == '0) begin
         m_eff = EFF_W'(1);
      end else if (int'(tap_count_ff) > MAX_TAPS) begin
         m_eff = EFF_W'(MAX_TAPS);
      end else begin
         m_eff = EFF_W'(tap_count_ff);
      end
   end

   // Input is held off while the tail of a sequence is flushed.
   assign flushing    = (flush_cnt_ff != '0);
   assign req_ready   = advance && !flushing;
   assign accept      = req_valid && req_ready;
   assign take_sample = accept && (req_item.action == ACT_SAMPLE);

   // Coefficient writes go straight to the addressed cell.
   assign coef_wr.en    = accept && (req_item.action == ACT_COEFF);
   assign coef_wr.index = req_item.coeff_index;
   assign coef_wr.value = req_item.coeff_value;

   // A step is a taken sample or one zero of the tail; the flush counter holds
   // the number of zero steps still to come.
   always_comb begin
      step         = '0;
      flush_cnt_in = flush_cnt_ff;
      if (take_sample) begin
         step.go      = 1'b1;
         step.data    = req_item.sample;
         step.seq_end = req_item.last && (m_eff == EFF_W'(1));
         if (req_item.last && (m_eff != EFF_W'(1))) begin
            flush_cnt_in = CNT_W'(m_eff - EFF_W'(1));
         end
      end else if (advance && flushing) begin
         step.go      = 1'b1;
         step.data    = '0;
         step.seq_end = (flush_cnt_ff == CNT_W'(1));
         flush_cnt_in = flush_cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flush_cnt_ff <= '0;
      end else begin
         flush_cnt_ff <= flush_cnt_in;
      end
   end

   // The tail never counts past the taps in use.
   a_flush_bound: assert property (@(posedge clock) disable iff (reset)
      int'(flush_cnt_ff) < int'(m_eff))
      else $error("flush count reached the tap count");

   // A last sample with more than one tap starts a flush.
   a_flush_start: assert property (@(posedge clock) disable iff (reset)
      (take_sample && req_item.last && (m_eff != EFF_W'(1))) |=> flushing)
      else $error("last sample did not start the tail flush");

   // A sequence ends only on a step, and a coefficient write is never a step.
   a_end_on_step: assert property (@(posedge clock) disable iff (reset)
      step.seq_end |-> (step.go && !coef_wr.en))
      else $error("sequence end without a step");

endmodule
